FILE: hdl/htwd_pkg.sv
// shared types and constants of the huffman tree walk decoder
package htwd_pkg;

   localparam int NODE_COUNT = 512;
   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int IDX_W = 9;
   localparam int SYM_W = 8;
   localparam int CNT_W = 56;
   localparam int ENTRY_W = 19;
   localparam int LEAF_BIT = 18;

   localparam logic REQ_NODE_WRITE = 1'b0;
   localparam logic REQ_DATA_BYTE = 1'b1;

   typedef logic [ENTRY_W-1:0] entry_type;

   typedef struct packed {
      logic             req_type;
      logic [IDX_W-1:0] node_index;
      logic             node_is_leaf;
      logic [IDX_W-1:0] child_zero;
      logic [IDX_W-1:0] child_one;
      logic [SYM_W-1:0] leaf_symbol;
      logic [SYM_W-1:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last_of_run;
      logic             all_done;
   } rsp_word_type;

endpackage

FILE: hdl/huffman_tree_walk_decoder_core.sv
// huffman tree walk decoder: node store memory and bit walker
//
// A node write leaves busy low. A data byte holds busy while it walks up to eight bits,
// through one more node read when the last bit walked ends on a read, through a stall each
// time a read reaches a leaf while the root itself is a leaf, and through the flush state
// that sends its last symbol when it yields any; a byte that finds the count at zero walks
// no bit. Each bit walked from an internal node needs one read of the 512 x 19 node store,
// whose registered data steers the next read address, so the walk runs at one bit per
// cycle unless it stalls. Symbols appear on rsp_word for exactly one cycle with
// rsp_strobe high; the receiver cannot stall them. The node store is not cleared after
// reset, so every node that a walk reaches must be written first. The symbol count register
// is taken on csr_valid and csr_ready while the core is idle and no start is offered.
module huffman_tree_walk_decoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  htwd_pkg::req_word_type      req_word,
   output logic                        rsp_strobe,
   output htwd_pkg::rsp_word_type      rsp_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [htwd_pkg::CNT_W-1:0]  csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_type;

   localparam logic [htwd_pkg::IDX_W:0] NODE_LIMIT = (htwd_pkg::IDX_W + 1)'(htwd_pkg::NODE_COUNT);

   state_type                    state_ff, state_in;
   logic [htwd_pkg::SYM_W-1:0]   byte_ff, byte_in;
   logic [3:0]                   bit_ff, bit_in;
   logic                         pend_ff, pend_in;
   logic                         pend_oob_ff, pend_oob_in;
   logic [htwd_pkg::IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [htwd_pkg::IDX_W-1:0]   current_ff, current_in;
   htwd_pkg::entry_type          cur_entry_ff, cur_entry_in;
   htwd_pkg::entry_type          root_ff, root_in;
   logic [htwd_pkg::CNT_W-1:0]   left_ff, left_in;
   logic                         hold_v_ff, hold_v_in;
   logic [htwd_pkg::SYM_W-1:0]   hold_sym_ff, hold_sym_in;
   logic                         hold_done_ff, hold_done_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   htwd_pkg::rsp_word_type       rsp_ff, rsp_in;

   htwd_pkg::entry_type          node_mem [htwd_pkg::NODE_COUNT];
   htwd_pkg::entry_type          rd_data_ff;
   logic                         mem_we, mem_re;
   logic [htwd_pkg::NODE_AW-1:0] mem_waddr, mem_raddr;
   htwd_pkg::entry_type          mem_wdata;

   htwd_pkg::entry_type          ent, cur_e, new_entry;
   logic [htwd_pkg::IDX_W-1:0]   cur_n, next_idx;
   logic [htwd_pkg::CNT_W-1:0]   left_a, left_b;
   logic                         a_emit, b_go, b_emit, emit, emit_done, done, bit_val;
   logic                         wr_oob;
   logic [htwd_pkg::SYM_W-1:0]   emit_sym;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= node_mem[mem_raddr];
      end
   end

   always_comb begin
      ent = pend_oob_ff ? '0 : rd_data_ff;
      a_emit = (state_ff == ST_RUN) && pend_ff && ent[htwd_pkg::LEAF_BIT];
      left_a = a_emit ? left_ff - htwd_pkg::CNT_W'(1) : left_ff;
      if (pend_ff) begin
         cur_e = ent[htwd_pkg::LEAF_BIT] ? root_ff : ent;
         cur_n = ent[htwd_pkg::LEAF_BIT] ? '0 : pend_idx_ff;
      end else begin
         cur_e = cur_entry_ff;
         cur_n = current_ff;
      end
      bit_val = byte_ff[bit_ff[2:0]];
      b_go = (state_ff == ST_RUN) && !bit_ff[3] && (left_a != '0) &&
             !(a_emit && cur_e[htwd_pkg::LEAF_BIT]);
      b_emit = b_go && cur_e[htwd_pkg::LEAF_BIT];
      left_b = b_emit ? left_a - htwd_pkg::CNT_W'(1) : left_a;
      next_idx = bit_val ? cur_e[2*htwd_pkg::IDX_W-1:htwd_pkg::IDX_W]
                         : cur_e[htwd_pkg::IDX_W-1:0];
      emit = a_emit || b_emit;
      emit_sym = a_emit ? ent[htwd_pkg::SYM_W-1:0] : cur_e[htwd_pkg::SYM_W-1:0];
      emit_done = a_emit ? (left_a == '0) : (left_b == '0);

      if (req_word.node_is_leaf) begin
         new_entry = {1'b1, (htwd_pkg::ENTRY_W - 1 - htwd_pkg::SYM_W)'(0),
                      req_word.leaf_symbol};
      end else begin
         new_entry = {1'b0, req_word.child_one, req_word.child_zero};
      end
      wr_oob = {1'b0, req_word.node_index} >= NODE_LIMIT;

      mem_we = 1'b0;
      mem_waddr = htwd_pkg::NODE_AW'(req_word.node_index);
      mem_wdata = new_entry;
      mem_re = 1'b0;
      mem_raddr = htwd_pkg::NODE_AW'(next_idx);

      state_in = state_ff;
      byte_in = byte_ff;
      bit_in = bit_ff;
      pend_in = pend_ff;
      pend_oob_in = pend_oob_ff;
      pend_idx_in = pend_idx_ff;
      current_in = current_ff;
      cur_entry_in = cur_entry_ff;
      root_in = root_ff;
      left_in = left_ff;
      hold_v_in = hold_v_ff;
      hold_sym_in = hold_sym_ff;
      hold_done_in = hold_done_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      done = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_word.req_type == htwd_pkg::REQ_NODE_WRITE) begin
                  if (!wr_oob) begin
                     mem_we = 1'b1;
                     if (req_word.node_index == '0) begin
                        root_in = new_entry;
                     end
                     if (req_word.node_index == current_ff) begin
                        cur_entry_in = new_entry;
                     end
                  end
               end else begin
                  state_in = ST_RUN;
                  byte_in = req_word.data_byte;
                  bit_in = '0;
                  pend_in = 1'b0;
               end
            end else if (csr_valid) begin
               left_in = csr_data;
               current_in = '0;
               cur_entry_in = root_ff;
            end
         end
         ST_RUN: begin
            left_in = left_b;
            bit_in = bit_ff + {3'b000, b_go};
            if (b_go && !b_emit) begin
               mem_re = 1'b1;
               pend_in = 1'b1;
               pend_idx_in = next_idx;
               pend_oob_in = {1'b0, next_idx} >= NODE_LIMIT;
               current_in = cur_n;
               cur_entry_in = cur_e;
            end else if (b_emit) begin
               pend_in = 1'b0;
               current_in = '0;
               cur_entry_in = root_ff;
            end else begin
               pend_in = 1'b0;
               current_in = cur_n;
               cur_entry_in = cur_e;
            end
            if (emit) begin
               if (hold_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{symbol: hold_sym_ff, last_of_run: 1'b0, all_done: hold_done_ff};
               end
               hold_v_in = 1'b1;
               hold_sym_in = emit_sym;
               hold_done_in = emit_done;
            end
            done = !pend_in && (bit_in[3] || (left_b == '0));
            if (done) begin
               state_in = hold_v_in ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{symbol: hold_sym_ff, last_of_run: 1'b1, all_done: hold_done_ff};
            hold_v_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bit_ff <= '0;
         pend_ff <= 1'b0;
         pend_oob_ff <= 1'b0;
         current_ff <= '0;
         left_ff <= '0;
         hold_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bit_ff <= bit_in;
         pend_ff <= pend_in;
         pend_oob_ff <= pend_oob_in;
         current_ff <= current_in;
         left_ff <= left_in;
         hold_v_ff <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff <= byte_in;
      pend_idx_ff <= pend_idx_in;
      cur_entry_ff <= cur_entry_in;
      root_ff <= root_in;
      hold_sym_ff <= hold_sym_in;
      hold_done_ff <= hold_done_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   // a read is only outstanding while walking a byte
   assert property (@(posedge clock) disable iff (reset) pend_ff |-> (state_ff == ST_RUN))
      else $error("node read outstanding outside of a walk");

   // the flush state sends the held symbol, marked last_of_run, and returns to idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |=> (rsp_valid_ff && rsp_ff.last_of_run && state_ff == ST_IDLE))
      else $error("last symbol of a byte not sent");

   // a word flagged all_done leaves no symbols to decode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.all_done) |-> (left_ff == '0))
      else $error("all_done sent with symbols left");

endmodule

FILE: tb/tb_huffman_tree_walk_decoder_core.sv
// testbench for the huffman tree walk decoder core: builds code trees, streams bytes, checks symbols
`timescale 1ns / 100ps

module tb_huffman_tree_walk_decoder_core;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start;
   logic                        busy;
   htwd_pkg::req_word_type      req_word;
   logic                        rsp_strobe;
   htwd_pkg::rsp_word_type      rsp_word;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [htwd_pkg::CNT_W-1:0]  csr_data;

   htwd_pkg::entry_type         node_mem [htwd_pkg::NODE_COUNT];
   logic [htwd_pkg::IDX_W-1:0]  walk_node;
   logic [htwd_pkg::CNT_W-1:0]  symbols_left;
   htwd_pkg::rsp_word_type      expected_symbols [$];
   bit                          node_written [htwd_pkg::NODE_COUNT];
   int                          written_nodes [$];
   bit                          gaps_enabled;
   int                          error_count = 0;
   int                          cycle_count = 0;
   int                          node_writes = 0;
   int                          data_bytes = 0;
   int                          symbols_seen = 0;
   int                          count_loads = 0;

   huffman_tree_walk_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // walk predictor: updates node store, walk position and remaining count
   function automatic void apply_request(input htwd_pkg::req_word_type w);
      htwd_pkg::entry_type         cur;
      htwd_pkg::entry_type         ent;
      logic [htwd_pkg::IDX_W-1:0]  nxt;
      htwd_pkg::rsp_word_type      sym_word;
      htwd_pkg::rsp_word_type      byte_symbols [$];
      if (w.req_type == htwd_pkg::REQ_NODE_WRITE) begin
         if (w.node_is_leaf)
            node_mem[w.node_index] = {1'b1,
               {(htwd_pkg::ENTRY_W-1-htwd_pkg::SYM_W){1'b0}}, w.leaf_symbol};
         else
            node_mem[w.node_index] = {1'b0, w.child_one, w.child_zero};
         return;
      end
      for (int b = 0; b < 8 && symbols_left != '0; b++) begin
         cur = node_mem[walk_node];
         if (cur[htwd_pkg::LEAF_BIT]) begin
            ent = cur;
            nxt = walk_node;
         end else begin
            nxt = w.data_byte[b] ? cur[2*htwd_pkg::IDX_W-1:htwd_pkg::IDX_W]
                                 : cur[htwd_pkg::IDX_W-1:0];
            ent = node_mem[nxt];
         end
         if (ent[htwd_pkg::LEAF_BIT]) begin
            symbols_left = symbols_left - htwd_pkg::CNT_W'(1);
            sym_word.symbol = ent[htwd_pkg::SYM_W-1:0];
            sym_word.last_of_run = 1'b0;
            sym_word.all_done = (symbols_left == '0);
            byte_symbols.push_back(sym_word);
            walk_node = '0;
         end else begin
            walk_node = nxt;
         end
      end
      if (byte_symbols.size() > 0)
         byte_symbols[byte_symbols.size()-1].last_of_run = 1'b1;
      foreach (byte_symbols[i])
         expected_symbols.push_back(byte_symbols[i]);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_symbols.size() == 0) begin
            $error("unexpected symbol word %0h", rsp_word);
            error_count++;
         end else begin
            symbols_seen++;
            if (rsp_word.symbol !== expected_symbols[0].symbol) begin
               $error("symbol: expected %0h, got %0h", expected_symbols[0].symbol,
                      rsp_word.symbol);
               error_count++;
            end
            if (rsp_word.last_of_run !== expected_symbols[0].last_of_run) begin
               $error("last_of_run: expected %0b, got %0b", expected_symbols[0].last_of_run,
                      rsp_word.last_of_run);
               error_count++;
            end
            if (rsp_word.all_done !== expected_symbols[0].all_done) begin
               $error("all_done: expected %0b, got %0b", expected_symbols[0].all_done,
                      rsp_word.all_done);
               error_count++;
            end
            void'(expected_symbols.pop_front());
         end
      end
   end

   task automatic send_word(input htwd_pkg::req_word_type w);
      while (gaps_enabled && $urandom_range(99) < 26) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy !== 1'b0);
      apply_request(w);
      if (w.req_type == htwd_pkg::REQ_NODE_WRITE) begin
         node_writes++;
         if (!node_written[w.node_index]) begin
            node_written[w.node_index] = 1'b1;
            written_nodes.push_back(int'(w.node_index));
         end
      end else begin
         data_bytes++;
      end
      @(negedge clock);
   endtask

   task automatic write_node(input logic [htwd_pkg::IDX_W-1:0] idx, input logic leaf,
                             input logic [htwd_pkg::IDX_W-1:0] c0,
                             input logic [htwd_pkg::IDX_W-1:0] c1,
                             input logic [htwd_pkg::SYM_W-1:0] sym);
      htwd_pkg::req_word_type w;
      w.req_type = htwd_pkg::REQ_NODE_WRITE;
      w.node_index = idx;
      w.node_is_leaf = leaf;
      w.child_zero = leaf ? htwd_pkg::IDX_W'($urandom) : c0;
      w.child_one = leaf ? htwd_pkg::IDX_W'($urandom) : c1;
      w.leaf_symbol = leaf ? sym : htwd_pkg::SYM_W'($urandom);
      w.data_byte = htwd_pkg::SYM_W'($urandom);
      send_word(w);
   endtask

   task automatic send_byte(input logic [htwd_pkg::SYM_W-1:0] value);
      htwd_pkg::req_word_type w;
      w.req_type = htwd_pkg::REQ_DATA_BYTE;
      w.node_index = htwd_pkg::IDX_W'($urandom);
      w.node_is_leaf = 1'($urandom);
      w.child_zero = htwd_pkg::IDX_W'($urandom);
      w.child_one = htwd_pkg::IDX_W'($urandom);
      w.leaf_symbol = htwd_pkg::SYM_W'($urandom);
      w.data_byte = value;
      send_word(w);
   endtask

   task automatic drain_symbols;
      start <= 1'b0;
      @(negedge clock);
      while (expected_symbols.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic load_symbol_count(input logic [htwd_pkg::CNT_W-1:0] value);
      drain_symbols();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      symbols_left = value;
      walk_node = '0;
      count_loads++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // rewrite a stored node, children only point at stored nodes
   task automatic write_noise_node;
      int idx;
      idx = written_nodes[$urandom_range(written_nodes.size()-1)];
      if ($urandom_range(1))
         write_node(htwd_pkg::IDX_W'(idx), 1'b1, '0, '0, htwd_pkg::SYM_W'($urandom));
      else
         write_node(htwd_pkg::IDX_W'(idx), 1'b0,
                    htwd_pkg::IDX_W'(written_nodes[$urandom_range(written_nodes.size()-1)]),
                    htwd_pkg::IDX_W'(written_nodes[$urandom_range(written_nodes.size()-1)]),
                    '0);
   endtask

   // bottom-up random tree, root ends at node 0
   task automatic build_random_tree(input int leaves);
      bit taken [htwd_pkg::NODE_COUNT];
      int pool [$];
      int idx;
      int a;
      int c;
      int r;
      if (leaves == 1) begin
         write_node('0, 1'b1, '0, '0, htwd_pkg::SYM_W'($urandom));
         return;
      end
      taken[0] = 1'b1;
      for (int i = 0; i < leaves; i++) begin
         do idx = $urandom_range(1, htwd_pkg::NODE_COUNT-1); while (taken[idx]);
         taken[idx] = 1'b1;
         write_node(htwd_pkg::IDX_W'(idx), 1'b1, '0, '0, htwd_pkg::SYM_W'($urandom));
         pool.push_back(idx);
      end
      while (pool.size() > 1) begin
         r = $urandom_range(pool.size()-1);
         a = pool[r];
         pool.delete(r);
         r = $urandom_range(pool.size()-1);
         c = pool[r];
         pool.delete(r);
         if (pool.size() == 0) begin
            idx = 0;
         end else begin
            do idx = $urandom_range(1, htwd_pkg::NODE_COUNT-1); while (taken[idx]);
            taken[idx] = 1'b1;
         end
         write_node(htwd_pkg::IDX_W'(idx), 1'b0, htwd_pkg::IDX_W'(a),
                    htwd_pkg::IDX_W'(c), '0);
         pool.push_back(idx);
      end
   endtask

   task automatic test_root_leaf;
      write_node('0, 1'b1, '0, '0, 8'hff);
      load_symbol_count(htwd_pkg::CNT_W'(3));
      send_byte(8'h00);
      send_byte(8'hc3);
      load_symbol_count('0);
      send_byte(8'hff);
      load_symbol_count(htwd_pkg::CNT_W'(1));
      send_byte(8'h96);
   endtask

   task automatic test_two_leaf_tree;
      write_node(htwd_pkg::IDX_W'(htwd_pkg::NODE_COUNT-1), 1'b1, '0, '0, 8'h00);
      write_node(htwd_pkg::IDX_W'(1), 1'b1, '0, '0, 8'ha5);
      write_node('0, 1'b0, htwd_pkg::IDX_W'(htwd_pkg::NODE_COUNT-1),
                 htwd_pkg::IDX_W'(1), '0);
      load_symbol_count('1);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h5a);
   endtask

   // chain longer than a byte, walk carries over into the next word
   task automatic test_deep_chain;
      write_node(htwd_pkg::IDX_W'(2), 1'b1, '0, '0, 8'h11);
      write_node(htwd_pkg::IDX_W'(20), 1'b1, '0, '0, 8'h80);
      write_node(htwd_pkg::IDX_W'(17), 1'b0, htwd_pkg::IDX_W'(2), htwd_pkg::IDX_W'(20), '0);
      for (int k = 16; k >= 10; k--)
         write_node(htwd_pkg::IDX_W'(k), 1'b0, htwd_pkg::IDX_W'(2),
                    htwd_pkg::IDX_W'(k + 1), '0);
      write_node('0, 1'b0, htwd_pkg::IDX_W'(2), htwd_pkg::IDX_W'(10), '0);
      load_symbol_count(htwd_pkg::CNT_W'(5));
      send_byte(8'hff);
      send_byte(8'h01);
   endtask

   task automatic test_random_trees;
      logic [63:0]                 wide;
      logic [htwd_pkg::CNT_W-1:0]  cnt;
      int                          n_bytes;
      for (int p = 0; p < 7; p++) begin
         gaps_enabled = (p != 3);
         build_random_tree((p == 5) ? 1 : $urandom_range(2, 10));
         case ($urandom_range(4))
            0: cnt = htwd_pkg::CNT_W'(1);
            1: cnt = htwd_pkg::CNT_W'($urandom_range(2, 40));
            2: cnt = htwd_pkg::CNT_W'($urandom_range(41, 150));
            3: cnt = '1;
            default: begin
               wide = {$urandom, $urandom};
               cnt = wide[htwd_pkg::CNT_W-1:0];
            end
         endcase
         load_symbol_count(cnt);
         n_bytes = $urandom_range(6, 12);
         for (int i = 0; i < n_bytes; i++) begin
            if (i == n_bytes / 2 && $urandom_range(2) == 0)
               drain_symbols();
            if ($urandom_range(9) == 0)
               write_noise_node();
            send_byte(htwd_pkg::SYM_W'($urandom));
         end
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin
      start = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      walk_node = '0;
      symbols_left = '0;
      gaps_enabled = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_root_leaf();
      test_two_leaf_tree();
      test_deep_chain();
      test_random_trees();
      drain_symbols();
      $display("sent %0d node writes and %0d data bytes under %0d count loads",
               node_writes, data_bytes, count_loads);
      $display("checked %0d decoded symbols, %0d mismatches", symbols_seen, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
